// File: rtl/bgnc_pkg.sv
// Shared types and constants for the binary grid neighbor count block.
package bgnc_pkg;

  // Width of the size registers and of all grid position counters
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned PosOutW = 10;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SlotW   = 2;
  localparam int unsigned Slots   = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COL_COUNT = 1'b1;

  // Input opcodes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic op;
    logic mined;
  } cell_t;

  typedef struct packed {
    logic [CountW-1:0]  count;
    logic [PosOutW-1:0] out_row;
    logic [PosOutW-1:0] out_col;
    logic               last;
  } result_t;

  // Control handed from the position logic to the window stage with each read
  typedef struct packed {
    logic [PosOutW-1:0] row;
    logic [PosOutW-1:0] col;
    logic               last;
    logic               up_ok;     // row above is inside the grid
    logic               dn_ok;     // row below is inside the grid
    logic               lt_ok;     // column left is inside the grid
    logic               rt_ok;     // column right is inside the grid
    logic [SlotW-1:0]   slot;      // line store slot of the center row
    logic               byp_a;     // same-cycle write hits the center column read
    logic               byp_b;     // same-cycle write hits the right column read
    logic [SlotW-1:0]   byp_slot;
    logic               byp_dat;
  } issue_t;

endpackage

// File: rtl/bgnc_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface bgnc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bgnc_ram.sv
// Generic RAM: one write port, two registered read ports, read-first.
module bgnc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                           rdata_a_o,
  output logic [WIDTH-1:0]                           rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports hold their data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/bgnc_window.sv
// Window stage: assembles the 3x3 neighborhood from line store reads and sums it.
module bgnc_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_vld_i,
  input  bgnc_pkg::issue_t                    issue_i,
  output logic                                take_o,
  input  logic [bgnc_pkg::Slots-1:0]          rd_a_i,
  input  logic [bgnc_pkg::Slots-1:0]          rd_b_i,
  bgnc_stream_if.source                       result_o
);

  logic                         b_vld_q;
  bgnc_pkg::issue_t             b_q;
  logic                         b_adv;
  logic [2:0]                   prev_col_q;
  logic                         o_vld_q;
  bgnc_pkg::result_t            o_q;

  logic [bgnc_pkg::Slots-1:0]   col_a_raw;
  logic [bgnc_pkg::Slots-1:0]   col_b_raw;
  logic [bgnc_pkg::SlotW-1:0]   slot_up;
  logic [bgnc_pkg::SlotW-1:0]   slot_dn;
  logic [2:0]                   col_l;
  logic [2:0]                   col_a;
  logic [2:0]                   col_b;
  logic [bgnc_pkg::CountW-1:0]  count;

  // stage advances when the output register is free or being emptied
  assign b_adv  = b_vld_q && (!o_vld_q || result_o.ready);
  assign take_o = !b_vld_q || b_adv;

  // patch in a cell that was written in the same cycle as the read
  always_comb begin
    col_a_raw = rd_a_i;
    col_b_raw = rd_b_i;
    if (b_q.byp_a) begin
      col_a_raw[b_q.byp_slot] = b_q.byp_dat;
    end
    if (b_q.byp_b) begin
      col_b_raw[b_q.byp_slot] = b_q.byp_dat;
    end
  end

  // pick rows above, at and below the center, clipped at the grid edges
  assign slot_up = b_q.slot - bgnc_pkg::SlotW'(1);
  assign slot_dn = b_q.slot + bgnc_pkg::SlotW'(1);

  assign col_a = {col_a_raw[slot_dn] & b_q.dn_ok, col_a_raw[b_q.slot],
                  col_a_raw[slot_up] & b_q.up_ok};
  assign col_b = {col_b_raw[slot_dn] & b_q.dn_ok, col_b_raw[b_q.slot],
                  col_b_raw[slot_up] & b_q.up_ok} & {3{b_q.rt_ok}};
  assign col_l = prev_col_q & {3{b_q.lt_ok}};

  assign count = bgnc_pkg::CountW'($countones({col_l, col_a, col_b}));

  // stage and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (take_o) begin
        b_vld_q <= issue_vld_i;
      end
      if (b_adv) begin
        o_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_o && issue_vld_i) begin
      b_q <= issue_i;
    end
    if (b_adv) begin
      prev_col_q    <= col_a;
      o_q.count     <= count;
      o_q.out_row   <= b_q.row;
      o_q.out_col   <= b_q.col;
      o_q.last      <= b_q.last;
    end
  end

  assign result_o.valid = o_vld_q;
  assign result_o.data  = o_q;

endmodule

// File: rtl/binary_grid_neighbor_count.sv
// Top level: streaming 3x3 box sum over a binary grid in raster order.
//
//  channel   dir  handshake        payload
//  cell_i    in   valid/ready      op, mined
//  result_o  out  valid/ready      count, out_row, out_col, last
//  cfg       in   cfg_we_i         cfg_idx_i (0 rows, 1 cols), cfg_data_i
//
// One beat accepted per cycle unless the output stalls; a released result goes
// through the line store read, then the window sum into the output register.
// The first result of a frame needs about one row plus two cells of input.
// Reset clears sizes to 1x1 and all positions; the line store is not cleared.
// A stalled output holds the window stage, which drops cell_i.ready.
module binary_grid_neighbor_count #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bgnc_stream_if.sink                       cell_i,
  bgnc_stream_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [bgnc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bgnc_pkg::CfgW-1:0]         cfg_data_i
);

  localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW    = bgnc_pkg::CfgW;

  logic [CW-1:0] row_cnt_q, row_cnt_d;
  logic [CW-1:0] col_cnt_q, col_cnt_d;
  logic [CW-1:0] in_row_q,  in_row_d;
  logic [CW-1:0] in_col_q,  in_col_d;
  logic [CW-1:0] em_row_q,  em_row_d;
  logic [CW-1:0] em_col_q,  em_col_d;

  logic                 acc;
  logic                 take_cell;
  logic                 win_take;
  logic [CW-1:0]        in_row_n;
  logic [CW-1:0]        in_col_n;
  logic [CW-1:0]        in_col_inc;
  logic [CW-1:0]        em_row_inc;
  logic [CW-1:0]        em_col_inc;
  logic                 dn_ok;
  logic                 rt_ok;
  logic [CW-1:0]        need_row;
  logic [CW-1:0]        need_col;
  logic                 rdy;
  logic                 emit;
  logic                 is_last;
  logic [CW-1:0]        cfg_size;
  bgnc_pkg::issue_t     issue;

  logic [AddrW-1:0]              waddr;
  logic [AddrW-1:0]              raddr_a;
  logic [AddrW-1:0]              raddr_b;
  logic [bgnc_pkg::Slots-1:0]    rd_a;
  logic [bgnc_pkg::Slots-1:0]    rd_b;

  assign acc          = cell_i.valid && win_take;
  assign cell_i.ready = win_take;

  // clamp a size write: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    cfg_size = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_size = CW'(1);
    end else if (cfg_idx_i == bgnc_pkg::CFG_ROW_COUNT) begin
      if (32'(cfg_data_i) > MAX_ROWS) begin
        cfg_size = CW'(MAX_ROWS);
      end
    end else if (32'(cfg_data_i) > MAX_COLS) begin
      cfg_size = CW'(MAX_COLS);
    end
  end

  // input raster position after storing this beat's cell
  assign take_cell  = acc && (cell_i.data.op == bgnc_pkg::OP_CELL) &&
                      (in_row_q < row_cnt_q);
  assign in_col_inc = in_col_q + CW'(1);

  always_comb begin
    in_row_n = in_row_q;
    in_col_n = in_col_q;
    if (take_cell) begin
      if (in_col_inc >= col_cnt_q) begin
        in_col_n = '0;
        in_row_n = in_row_q + CW'(1);
      end else begin
        in_col_n = in_col_inc;
      end
    end
  end

  // the oldest pending cell is ready once its lower right neighbor has arrived
  assign em_row_inc = em_row_q + CW'(1);
  assign em_col_inc = em_col_q + CW'(1);
  assign dn_ok      = em_row_inc < row_cnt_q;
  assign rt_ok      = em_col_inc < col_cnt_q;
  assign need_row   = dn_ok ? em_row_inc : em_row_q;
  assign need_col   = rt_ok ? em_col_inc : em_col_q;
  assign rdy        = (in_row_n > need_row) ||
                      ((in_row_n == need_row) && (in_col_n > need_col));
  assign emit       = acc && rdy;
  assign is_last    = !dn_ok && !rt_ok;

  // position and size registers, next state
  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    in_row_d  = in_row_n;
    in_col_d  = in_col_n;
    em_row_d  = em_row_q;
    em_col_d  = em_col_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == bgnc_pkg::CFG_ROW_COUNT) begin
        row_cnt_d = cfg_size;
      end else begin
        col_cnt_d = cfg_size;
      end
      in_row_d = '0;
      in_col_d = '0;
      em_row_d = '0;
      em_col_d = '0;
    end else if (emit) begin
      if (is_last) begin
        in_row_d = '0;
        in_col_d = '0;
        em_row_d = '0;
        em_col_d = '0;
      end else if (rt_ok) begin
        em_col_d = em_col_inc;
      end else begin
        em_col_d = '0;
        em_row_d = em_row_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= CW'(1);
      col_cnt_q <= CW'(1);
      in_row_q  <= '0;
      in_col_q  <= '0;
      em_row_q  <= '0;
      em_col_q  <= '0;
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      em_row_q  <= em_row_d;
      em_col_q  <= em_col_d;
    end
  end

  // line store: one bit-wide RAM per row slot, read at center and right columns
  assign waddr   = AddrW'(in_col_q);
  assign raddr_a = AddrW'(em_col_q);
  assign raddr_b = AddrW'(need_col);

  for (genvar s = 0; s < bgnc_pkg::Slots; s++) begin : g_slot
    bgnc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_COLS)
    ) u_line (
      .clk_i     (clk_i),
      .we_i      (take_cell && (in_row_q[bgnc_pkg::SlotW-1:0] ==
                                bgnc_pkg::SlotW'(s))),
      .waddr_i   (waddr),
      .wdata_i   (cell_i.data.mined),
      .re_i      (emit),
      .raddr_a_i (raddr_a),
      .raddr_b_i (raddr_b),
      .rdata_a_o (rd_a[s]),
      .rdata_b_o (rd_b[s])
    );
  end

  // control that travels with the read into the window stage
  always_comb begin
    issue.row      = em_row_q[bgnc_pkg::PosOutW-1:0];
    issue.col      = em_col_q[bgnc_pkg::PosOutW-1:0];
    issue.last     = is_last;
    issue.up_ok    = (em_row_q != '0);
    issue.dn_ok    = dn_ok;
    issue.lt_ok    = (em_col_q != '0);
    issue.rt_ok    = rt_ok;
    issue.slot     = em_row_q[bgnc_pkg::SlotW-1:0];
    issue.byp_a    = take_cell && (in_col_q == em_col_q);
    issue.byp_b    = take_cell && (in_col_q == need_col);
    issue.byp_slot = in_row_q[bgnc_pkg::SlotW-1:0];
    issue.byp_dat  = cell_i.data.mined;
  end

  bgnc_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_vld_i (emit),
    .issue_i     (issue),
    .take_o      (win_take),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .result_o    (result_o)
  );

  // emission never runs ahead of the input rows
  a_emit_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_row_q <= in_row_q)
    else $error("emit row ahead of input row");

  // input column stays inside the configured width
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q < col_cnt_q)
    else $error("input column out of range");

  // input row never passes the end of the frame
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= row_cnt_q)
    else $error("input row past frame end");

  // a stalled full output register blocks new beats
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready && !win_take) |=> !emit || win_take)
    else $error("beat accepted while window stage blocked");

endmodule

// File: verif/tb_binary_grid_neighbor_count.sv
// Testbench for binary_grid_neighbor_count: random grids, 3x3 box sums checked beat by beat.
module tb_binary_grid_neighbor_count;

  localparam int unsigned MaxRows      = 1024;
  localparam int unsigned MaxCols      = 1024;
  localparam int          Period       = 8;
  localparam int          ResetCycles  = 12;
  localparam int          SettleCycles = 8;    // covers the two-stage output pipe
  localparam int          HoldCycles   = 150;  // long result-side stall
  localparam int          StallLimit   = 2000; // cycles with no beat on either side
  localparam int unsigned CellBudget   = 200;
  localparam int unsigned ExtremeCells = 24;   // partial frames at the clipped sizes

  // Predicts box sums for the grid stream and holds the ones not yet seen
  class box_sum_board;
    int unsigned rows = 1;
    int unsigned cols = 1;
    bit          cells [bgnc_pkg::Slots][MaxCols];
    int unsigned in_r, in_c, em_r, em_c;
    bgnc_pkg::result_t due [$];
    int unsigned errors;
    int unsigned checked;

    function int unsigned fit(logic [bgnc_pkg::CfgW-1:0] v, int unsigned lim);
      if (v == '0) return 1;
      if (v > lim) return lim;
      return 32'(v);
    endfunction

    // Any size write starts a fresh frame and drops what is pending
    function void resize(logic [bgnc_pkg::CfgIdxW-1:0] idx, logic [bgnc_pkg::CfgW-1:0] v);
      if (idx == bgnc_pkg::CFG_ROW_COUNT) rows = fit(v, MaxRows);
      else cols = fit(v, MaxCols);
      in_r = 0; in_c = 0; em_r = 0; em_c = 0;
    endfunction

    function int unsigned owed();
      return (in_r * cols + in_c) - (em_r * cols + em_c);
    endfunction

    function void note_cell(bgnc_pkg::cell_t beat);
      int unsigned nr, nc, r0, r1, c0, c1, total_set;
      bgnc_pkg::result_t want;
      // store the flag unless the frame is already complete
      if (beat.op == bgnc_pkg::OP_CELL && in_r < rows) begin
        cells[in_r % bgnc_pkg::Slots][in_c] = beat.mined;
        in_c++;
        if (in_c >= cols) begin
          in_c = 0;
          in_r++;
        end
      end
      // oldest cell is ready once its lower-right neighbor (clipped) has arrived
      nr = (em_r + 1 < rows) ? em_r + 1 : rows - 1;
      nc = (em_c + 1 < cols) ? em_c + 1 : cols - 1;
      if (!(in_r > nr || (in_r == nr && in_c > nc))) return;
      r0 = (em_r > 0) ? em_r - 1 : 0;
      c0 = (em_c > 0) ? em_c - 1 : 0;
      r1 = nr;
      c1 = nc;
      total_set = 0;
      for (int unsigned r = r0; r <= r1; r++)
        for (int unsigned c = c0; c <= c1; c++)
          if (cells[r % bgnc_pkg::Slots][c]) total_set++;
      want.count   = bgnc_pkg::CountW'(total_set);
      want.out_row = bgnc_pkg::PosOutW'(em_r);
      want.out_col = bgnc_pkg::PosOutW'(em_c);
      want.last    = (em_r == rows - 1) && (em_c == cols - 1);
      due.push_back(want);
      if (want.last) begin
        in_r = 0; in_c = 0; em_r = 0; em_c = 0;
      end else begin
        em_c++;
        if (em_c >= cols) begin
          em_c = 0;
          em_r++;
        end
      end
    endfunction

    function void check_sum(bgnc_pkg::result_t got);
      bgnc_pkg::result_t want;
      if (due.size() == 0) begin
        $error("unexpected result beat: row %0d col %0d count %0d",
               got.out_row, got.out_col, got.count);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [bgnc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [bgnc_pkg::CfgW-1:0]    cfg_data_i;

  bgnc_stream_if #(.data_t(bgnc_pkg::cell_t))   cell_ch ();
  bgnc_stream_if #(.data_t(bgnc_pkg::result_t)) sum_ch ();

  binary_grid_neighbor_count #(
    .MAX_ROWS(MaxRows),
    .MAX_COLS(MaxCols)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cell_i    (cell_ch),
    .result_o  (sum_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  box_sum_board sums = new();

  bit          idle_mode;
  bit          calm;
  bit          hold_req;
  bit          hold_done;
  int unsigned cells_sent;
  int unsigned frames;
  int unsigned setups;
  int          quiet_cycles;

  initial clk_i = 1'b0;
  always #(Period / 2) clk_i = ~clk_i;

  // Result side: random ready bursts, plus one long hold-off on request
  initial begin
    sum_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        sum_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        sum_ch.ready <= 1'b1;
      end else if (idle_mode && !calm && $urandom_range(0, 4) == 0) begin
        sum_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        sum_ch.ready <= 1'b1;
      end else begin
        sum_ch.ready <= 1'b1;
      end
    end
  end

  // Result beats go to the checker; watchdog restarts on any beat
  always @(posedge clk_i) begin
    if (rst_ni && sum_ch.valid && sum_ch.ready) sums.check_sum(sum_ch.data);
    if ((cell_ch.valid && cell_ch.ready) || (sum_ch.valid && sum_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One input beat, with an optional gap in front of it
  task automatic send_beat(input logic op, input logic mined);
    bgnc_pkg::cell_t beat;
    beat.op    = op;
    beat.mined = mined;
    if (idle_mode && !calm && $urandom_range(0, 4) == 0) begin
      cell_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.data  <= beat;
    @(posedge clk_i);
    while (!cell_ch.ready) @(posedge clk_i);
    sums.note_cell(beat);
    if (op == bgnc_pkg::OP_CELL) cells_sent++;
  endtask

  // Stop sending and wait until every predicted sum is back
  task automatic await_drained();
    cell_ch.valid <= 1'b0;
    while (sums.due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [bgnc_pkg::CfgIdxW-1:0] idx,
                            input logic [bgnc_pkg::CfgW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sums.resize(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic play_cells(input int unsigned n, input int unsigned density, input bit noisy);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_beat(bgnc_pkg::OP_DRAIN, 1'($urandom));
      send_beat(bgnc_pkg::OP_CELL, $urandom_range(0, 99) < density);
    end
  endtask

  // After a complete frame: maybe a few ignored cells, then drain the rest
  task automatic close_frame(input bit noisy);
    int unsigned extras;
    extras = noisy ? $urandom_range(0, 3) : 0;
    while (extras > 0 && sums.owed() > 0) begin
      send_beat(bgnc_pkg::OP_CELL, 1'($urandom));
      extras--;
    end
    while (sums.owed() > 0) send_beat(bgnc_pkg::OP_DRAIN, 1'($urandom));
    frames++;
  endtask

  initial begin
    int unsigned start, total, density;
    bit          noisy;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = bgnc_pkg::CFG_ROW_COUNT;
    cfg_data_i    = '0;
    cell_ch.valid = 1'b0;
    cell_ch.data  = '0;
    idle_mode     = 1'b1;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 grid straight out of reset, then a drain with nothing pending
    send_beat(bgnc_pkg::OP_CELL, 1'b1);
    send_beat(bgnc_pkg::OP_CELL, 1'b0);
    send_beat(bgnc_pkg::OP_DRAIN, 1'b1);

    // full 3x3 of ones gives the maximum count; a late cell is ignored
    await_drained();
    write_size(bgnc_pkg::CFG_ROW_COUNT, 11'd3);
    write_size(bgnc_pkg::CFG_COL_COUNT, 11'd3);
    play_cells(9, 100, 1'b0);
    send_beat(bgnc_pkg::OP_CELL, 1'b0);
    close_frame(1'b0);

    // resize mid-frame drops the partial frame
    await_drained();
    write_size(bgnc_pkg::CFG_COL_COUNT, 11'd2);
    play_cells(3, 50, 1'b0);
    await_drained();
    write_size(bgnc_pkg::CFG_ROW_COUNT, 11'd2);
    send_beat(bgnc_pkg::OP_DRAIN, 1'b0);
    play_cells(4, 50, 1'b0);
    close_frame(1'b0);
    setups = 3;

    // size extremes: zero acts as one, all-ones clips to the maximum
    await_drained();
    write_size(bgnc_pkg::CFG_ROW_COUNT, '0);
    write_size(bgnc_pkg::CFG_COL_COUNT, '1);
    play_cells(ExtremeCells, 50, 1'b0);
    await_drained();
    write_size(bgnc_pkg::CFG_ROW_COUNT, '1);
    write_size(bgnc_pkg::CFG_COL_COUNT, '0);
    play_cells(ExtremeCells, 50, 1'b1);

    // long stall on the result side while cells keep coming
    await_drained();
    write_size(bgnc_pkg::CFG_ROW_COUNT, 11'd6);
    write_size(bgnc_pkg::CFG_COL_COUNT, 11'd12);
    hold_req = 1'b1;
    play_cells(72, 50, 1'b0);
    close_frame(1'b0);
    setups += 3;

    // random frames, mostly small, some tall and narrow, a few cut short
    start = cells_sent;
    while (cells_sent - start < CellBudget) begin
      calm      = (cells_sent - start) > CellBudget * 4 / 5;
      idle_mode = !calm && ($urandom_range(0, 3) != 0);
      await_drained();
      if ($urandom_range(0, 7) == 0) begin
        write_size(bgnc_pkg::CFG_ROW_COUNT, 11'($urandom_range(1, 30)));
        write_size(bgnc_pkg::CFG_COL_COUNT, 11'($urandom_range(1, 3)));
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          write_size(bgnc_pkg::CFG_ROW_COUNT, 11'($urandom_range(1, 6)));
        end
        write_size(bgnc_pkg::CFG_COL_COUNT, 11'($urandom_range(1, 10)));
      end
      case ($urandom_range(0, 3))
        0:       density = 0;
        1:       density = 30;
        2:       density = 60;
        default: density = 100;
      endcase
      noisy = $urandom_range(0, 2) == 0;
      total = sums.rows * sums.cols;
      if ($urandom_range(0, 7) == 0) begin
        play_cells($urandom_range(0, total - 1), density, noisy);
      end else begin
        repeat ($urandom_range(1, 2)) begin
          play_cells(total, density, noisy);
          close_frame(noisy);
        end
      end
      setups++;
    end

    // wind down with no idling
    calm = 1'b1;
    cell_ch.valid <= 1'b0;
    while (sums.due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d grid cells in %0d finished frames over %0d size setups (1x1 to 1024).",
             cells_sent, frames, setups);
    $display("Checked %0d result beats; %0d field mismatches.", sums.checked, sums.errors);
    if (sums.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
